// ----- src/rmaa_pkg.sv -----
// Shared types, constants and register codes for the row-major array store.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rmaa_pkg;

    localparam int RMAA_CELLS      = 4096;
    localparam int RMAA_DATA_WIDTH = 32;
    localparam int MAX_DIMS        = 4;

    localparam int DIMS        = 4;
    localparam int DIM_SEL_W   = 2;
    localparam int IDX_W       = 13;
    localparam int BOUND_W     = 13;
    localparam int CNT_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_DIM_COUNT = 3'd0;
    localparam logic [2:0] REG_BOUND_0   = 3'd1;
    localparam logic [2:0] REG_BOUND_1   = 3'd2;
    localparam logic [2:0] REG_BOUND_2   = 3'd3;
    localparam logic [2:0] REG_BOUND_3   = 3'd4;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]               dim_count;
        logic [DIMS-1:0][BOUND_W-1:0]   bound;
    } rmaa_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rmaa_qstat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WALK,
        F_PUSH
    } rmaa_fstate_t;

endpackage

// ----- src/rmaa_queue.sv -----
// Two-entry queue between the address front end and the store back end.
// Depends on rmaa_pkg for the depth and the status struct.
`timescale 1ns / 1ps

module rmaa_queue
    import rmaa_pkg::*;
#(
    parameter int ENTRY_W = 46
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head,
    output rmaa_qstat_t        status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- src/rmaa_front.sv -----
// Front end: takes a word, checks each index and folds the row-major offset,
// one dimension per cycle on a shared multiply-add. Depends on rmaa_pkg.
`timescale 1ns / 1ps

module rmaa_front
    import rmaa_pkg::*;
#(
    parameter int CELLS = RMAA_CELLS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          kind,
    input  logic [VALUE_W-1:0]            write_value,
    input  logic [DIMS-1:0][IDX_W-1:0]    index,
    input  rmaa_cfg_t                     cfg,
    input  rmaa_qstat_t                   q_status,
    output logic                          push,
    output logic [$clog2(CELLS)+VALUE_W+1:0] push_data
);

    localparam int AW = $clog2(CELLS);
    localparam int SW = AW + BOUND_W + 1;

    rmaa_fstate_t state_reg;
    rmaa_fstate_t state_next;

    logic                         kind_reg;
    logic [VALUE_W-1:0]           wval_reg;
    logic [DIMS-1:0][IDX_W-1:0]   idx_reg;
    logic [DIM_SEL_W-1:0]         dim_reg;
    logic [AW-1:0]                acc_reg;
    logic                         bad_reg;

    logic [DIM_SEL_W-1:0]         last_dim;
    logic [IDX_W-1:0]             idx;
    logic [BOUND_W-1:0]           bnd;
    logic [AW+BOUND_W-1:0]        prod;
    logic [SW-1:0]                sum;
    logic                         step_bad;
    logic                         accept;

    always_comb
    begin
        if (cfg.dim_count == '0)
        begin
            last_dim = '0;
        end
        else if (cfg.dim_count > CNT_W'(MAX_DIMS))
        begin
            last_dim = DIM_SEL_W'(MAX_DIMS - 1);
        end
        else
        begin
            last_dim = DIM_SEL_W'(cfg.dim_count - 1'b1);
        end
    end

    assign idx  = idx_reg[dim_reg];
    assign bnd  = cfg.bound[dim_reg];
    assign prod = {{BOUND_W{1'b0}}, acc_reg} * {{AW{1'b0}}, bnd};
    assign sum  = {1'b0, prod} + {{(SW-IDX_W){1'b0}}, idx};

    // A negative index, an index at or past its bound, or a partial offset
    // already past the store all reject the access.
    assign step_bad = idx[IDX_W-1] || (idx >= bnd) || (sum >= SW'(CELLS));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = F_WALK;
                end
            end
            F_WALK:
            begin
                if (dim_reg == last_dim)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                s_tready = 1'b1;
            end
            F_PUSH:
            begin
                push = !q_status.full;
            end
            default:
            begin
                s_tready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign push_data = {!bad_reg, kind_reg, wval_reg, acc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            wval_reg <= write_value;
            idx_reg  <= index;
            dim_reg  <= '0;
            acc_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else if (state_reg == F_WALK)
        begin
            acc_reg <= sum[AW-1:0];
            bad_reg <= bad_reg || step_bad;
            dim_reg <= dim_reg + 1'b1;
        end
    end

endmodule

// ----- src/rmaa_back.sv -----
// Back end: carries out queued accesses on the cell store and holds the
// result word in an output register. Depends on rmaa_pkg.
`timescale 1ns / 1ps

module rmaa_back
    import rmaa_pkg::*;
#(
    parameter int CELLS      = RMAA_CELLS,
    parameter int DATA_WIDTH = RMAA_DATA_WIDTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [$clog2(CELLS)+VALUE_W+1:0]    head,
    input  rmaa_qstat_t                         q_status,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_TDATA_W-1:0]                m_tdata,
    output logic                                m_tuser
);

    localparam int AW = $clog2(CELLS);

    logic [DATA_WIDTH-1:0] mem [CELLS];

    logic                  head_ok;
    logic                  head_kind;
    logic [VALUE_W-1:0]    head_wval;
    logic [AW-1:0]         head_off;
    logic [DATA_WIDTH+VALUE_W-1:0] wide_wr;
    logic [DATA_WIDTH+VALUE_W-1:0] wide_rd;

    logic                  s1_valid_reg;
    logic                  s1_ok_reg;
    logic                  s1_kind_reg;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic                  out_ok_reg;
    logic                  s1_move;

    assign {head_ok, head_kind, head_wval, head_off} = head;

    assign wide_wr = {{DATA_WIDTH{1'b0}}, head_wval};
    assign wide_rd = {{VALUE_W{1'b0}}, rd_reg};

    assign s1_move = s1_valid_reg && (!out_valid_reg || m_tready);
    assign pop     = !q_status.empty && (!s1_valid_reg || s1_move);

    always_ff @(posedge clk)
    begin
        if (pop && head_ok && (head_kind == KIND_WRITE))
        begin
            mem[head_off] <= wide_wr[DATA_WIDTH-1:0];
        end
        if (pop && head_ok && (head_kind == KIND_READ))
        begin
            rd_reg <= mem[head_off];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ok_reg   <= head_ok;
            s1_kind_reg <= head_kind;
        end
        if (s1_move)
        begin
            out_ok_reg   <= s1_ok_reg;
            out_data_reg <= (s1_ok_reg && (s1_kind_reg == KIND_READ)) ?
                            wide_rd[M_TDATA_W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    // The queue is never read while it holds nothing.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // A word leaving the middle stage always reaches the output register.
    assert property (@(posedge clk) disable iff (!rst_n) s1_move |=> m_tvalid)
        else $error("result word lost between stages");

    // Read data must hold while its access waits in the middle stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> $stable(rd_reg))
        else $error("read data changed under a waiting access");

    // A rejected access never carries data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected access returned non-zero data");

endmodule

// ----- src/row_major_array_access.sv -----
// Top level of the row-major array store: configuration registers, front end,
// queue and back end. Depends on rmaa_pkg, rmaa_front, rmaa_queue, rmaa_back.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  tdata: write_value, index_0..3; tuser: kind
//   m_*      out        m_tvalid/m_tready  tdata: read_data; tuser: ok
//   APB      in         psel/penable       dim_count at 0x00, bound_0..bound_3 at 0x04..0x10
//
// The front end takes a new word only after it has pushed the last one into the queue:
// its single multiply-add folds one index per cycle into the offset.
// After the front end hands it on, an access passes the queue, the middle stage and the output register.
// Reset leaves dim_count and every bound at one; the cell store is not cleared.
// The two-entry queue lets the front end keep working while the output stalls.
`timescale 1ns / 1ps

module row_major_array_access
    import rmaa_pkg::*;
#(
    parameter int CELLS      = RMAA_CELLS,
    parameter int DATA_WIDTH = RMAA_DATA_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // write_value, index_0, index_1, index_2, index_3
    input  logic                   s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // read_data
    output logic                   m_tuser,   // ok
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int ENTRY_W = $clog2(CELLS) + VALUE_W + 2;

    logic [CNT_W-1:0]             dim_count_reg;
    logic [DIMS-1:0][BOUND_W-1:0] bound_reg;
    logic [2:0]                   reg_sel;
    logic                         cfg_wr;
    rmaa_cfg_t                    cfg;

    logic [VALUE_W-1:0]           write_value;
    logic [DIMS-1:0][IDX_W-1:0]   index;

    logic                         push;
    logic [ENTRY_W-1:0]           push_data;
    logic                         pop;
    logic [ENTRY_W-1:0]           head;
    rmaa_qstat_t                  q_status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= CNT_W'(1);
            bound_reg     <= {DIMS{BOUND_W'(1)}};
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_DIM_COUNT: dim_count_reg <= pwdata[CNT_W-1:0];
                REG_BOUND_0:   bound_reg[0]  <= pwdata[BOUND_W-1:0];
                REG_BOUND_1:   bound_reg[1]  <= pwdata[BOUND_W-1:0];
                REG_BOUND_2:   bound_reg[2]  <= pwdata[BOUND_W-1:0];
                REG_BOUND_3:   bound_reg[3]  <= pwdata[BOUND_W-1:0];
                default:       dim_count_reg <= dim_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DIM_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, dim_count_reg};
            REG_BOUND_0:   prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, bound_reg[0]};
            REG_BOUND_1:   prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, bound_reg[1]};
            REG_BOUND_2:   prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, bound_reg[2]};
            REG_BOUND_3:   prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, bound_reg[3]};
            default:       prdata = '0;
        endcase
    end

    assign cfg.dim_count = dim_count_reg;
    assign cfg.bound     = bound_reg;

    assign write_value = s_tdata[VALUE_W-1:0];

    always_comb
    begin
        for (int d = 0; d < DIMS; d++)
        begin
            index[d] = s_tdata[VALUE_W + IDX_W*d +: IDX_W];
        end
    end

    rmaa_front #(
        .CELLS       (CELLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .kind        (s_tuser),
        .write_value (write_value),
        .index       (index),
        .cfg         (cfg),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    rmaa_queue #(
        .ENTRY_W     (ENTRY_W)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (push_data),
        .pop         (pop),
        .head        (head),
        .status      (q_status)
    );

    rmaa_back #(
        .CELLS       (CELLS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
